>>> hdl/dtc_rp_pkg.sv
// Shared types, reset values and ASCII helpers for the DTC response parser.
// No dependencies; imported by every module of the block.
package dtc_rp_pkg;

	localparam int MAX_PAYLOAD_BYTES_DEF = 4095;
	localparam int QUEUE_DEPTH_DEF       = 4;
	localparam int LEN_IN_W              = 12;
	localparam int LEN_IN_MAX            = 4095;

	localparam logic [7:0] SERVICE_CODE_RST = 8'h43;
	localparam logic [7:0] CODE_LIMIT_RST   = 8'd32;

	typedef enum logic [7:0] {
		REG_SERVICE_CODE = 8'd0,
		REG_CODE_LIMIT   = 8'd1
	} cfg_reg_t;

	typedef enum logic {
		KIND_CODE = 1'b0,
		KIND_END  = 1'b1
	} result_kind_t;

	// One entry per byte that causes results: a code, an end report, or both.
	typedef struct packed {
		logic       code_v;
		logic [7:0] hi;
		logic [7:0] lo;
		logic       end_v;
		logic [7:0] found;
		logic       status;
	} evt_t;

	function automatic logic [6:0] hex_char(input logic [3:0] nib);
		logic [6:0] r;
		if (nib < 4'd10)
			r = 7'h30 + {3'd0, nib};
		else
			r = 7'h37 + {3'd0, nib};
		return r;
	endfunction

	function automatic logic [6:0] letter_of(input logic [1:0] sel);
		logic [6:0] r;
		unique case (sel)
			2'd0: r = 7'h50; // P
			2'd1: r = 7'h43; // C
			2'd2: r = 7'h42; // B
			2'd3: r = 7'h55; // U
			default: r = 7'h50;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/dtc_response_parser_core.sv
// Top level of the DTC response parser: front end, event queue, back end.
// Depends on dtc_rp_pkg, dtc_rp_front, dtc_rp_fifo and dtc_rp_back.
// A result word passes through the event queue and then the output register; a
// second word from the same byte follows it out of the output register.
// Throughput: one byte per cycle while the event queue has room; a byte that yields
// a code and an end report gives two output words, absorbed by the event queue.
// Reset: service code 0x43, code limit 32, no payload in progress, queue empty.
module dtc_response_parser_core
	import dtc_rp_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
	parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                start_of_payload,
	input  logic [LEN_IN_W-1:0] payload_length,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                result_kind,
	output logic [7:0]          code_high,
	output logic [7:0]          code_low,
	output logic [6:0]          letter_char,
	output logic [5:0]          digit_char,
	output logic [6:0]          hex_char_a,
	output logic [6:0]          hex_char_b,
	output logic [6:0]          hex_char_c,
	output logic [7:0]          codes_found,
	output logic                status,
	output logic                last_of_run
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	evt_t push_data, pop_data;

	dtc_rp_front #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.start_of_payload (start_of_payload),
		.payload_length   (payload_length),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.evt_valid        (push_valid),
		.evt_ready        (push_ready),
		.evt              (push_data)
	);

	dtc_rp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	dtc_rp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt_valid   (pop_valid),
		.evt_ready   (pop_ready),
		.evt         (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_kind (result_kind),
		.code_high   (code_high),
		.code_low    (code_low),
		.letter_char (letter_char),
		.digit_char  (digit_char),
		.hex_char_a  (hex_char_a),
		.hex_char_b  (hex_char_b),
		.hex_char_c  (hex_char_c),
		.codes_found (codes_found),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

>>> hdl/dtc_rp_front.sv
// Front end: accepts payload bytes, tracks position, pairs code bytes and
// pushes result events. Holds the configuration registers. Uses dtc_rp_pkg.
module dtc_rp_front
	import dtc_rp_pkg::*;
#(
	parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                start_of_payload,
	input  logic [LEN_IN_W-1:0] payload_length,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	output logic                evt_valid,
	input  logic                evt_ready,
	output evt_t                evt
);

	localparam int MAX_LEN = (MAX_PAYLOAD_BYTES > LEN_IN_MAX) ? LEN_IN_MAX : MAX_PAYLOAD_BYTES;
	localparam int LEN_W   = $clog2(MAX_LEN + 1);

	logic [7:0]       svc_q;
	logic [7:0]       limit_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;
	logic             cbp_q;
	logic [7:0]       pend_q;
	logic [7:0]       emitted_q;
	logic             mism_q;

	logic             accept;
	logic [LEN_W-1:0] len_in;
	logic [LEN_W-1:0] pos_nx;
	logic             active;
	logic             past_off;
	logic             is_high;
	logic             code_c;
	logic             end_c;
	logic             mism_c;
	logic [7:0]       emitted_nx;

	assign cfg_ready = 1'b1;
	assign in_ready  = evt_ready;
	assign accept    = in_valid & in_ready;

	always_comb begin
		if (payload_length > LEN_IN_W'(MAX_LEN))
			len_in = LEN_W'(MAX_LEN);
		else
			len_in = payload_length[LEN_W-1:0];
		if (len_in == '0)
			len_in = LEN_W'(1);
	end

	assign active   = pos_q < len_q;
	assign pos_nx   = pos_q + LEN_W'(1);
	assign past_off = cbp_q ? (pos_q >= LEN_W'(2)) : (pos_q >= LEN_W'(1));
	assign is_high  = (pos_q[0] == ~cbp_q);

	assign code_c = !start_of_payload && active && !mism_q && past_off && !is_high
		&& ((pend_q | data_byte) != 8'd0) && (emitted_q < limit_q);
	assign emitted_nx = emitted_q + {7'd0, code_c};
	assign mism_c = start_of_payload ? (data_byte != svc_q) : mism_q;
	assign end_c  = start_of_payload ? (len_in == LEN_W'(1)) : (active && pos_nx == len_q);

	always_comb begin
		evt.code_v = code_c;
		evt.hi     = pend_q;
		evt.lo     = data_byte;
		evt.end_v  = end_c;
		evt.status = mism_c;
		evt.found  = (mism_c || start_of_payload) ? 8'd0 : emitted_nx;
	end

	assign evt_valid = accept & (code_c | end_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			svc_q   <= SERVICE_CODE_RST;
			limit_q <= CODE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SERVICE_CODE: svc_q   <= cfg_data;
				REG_CODE_LIMIT:   limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			len_q     <= '0;
			cbp_q     <= 1'b0;
			emitted_q <= 8'd0;
			mism_q    <= 1'b0;
		end else if (accept) begin
			if (start_of_payload) begin
				len_q     <= len_in;
				cbp_q     <= ~len_in[0];
				mism_q    <= mism_c;
				emitted_q <= 8'd0;
				pos_q     <= LEN_W'(1);
			end else if (active) begin
				emitted_q <= emitted_nx;
				pos_q     <= pos_nx;
			end
		end
	end

	// pending high byte: always written before it is read
	always_ff @(posedge clk) begin
		if (accept && !start_of_payload && active && !mism_q && past_off && is_high)
			pend_q <= data_byte;
	end

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= len_q)
		else $error("byte position past payload length");

	a_code_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt.code_v |-> !evt.status && $past(1'b1))
		else $error("code pushed for mismatched service");

endmodule

>>> hdl/dtc_rp_fifo.sv
// Short event queue between front and back ends, flip-flop storage.
// Uses dtc_rp_pkg for the event type.
module dtc_rp_fifo
	import dtc_rp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  evt_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output evt_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	evt_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count over depth");

	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("queue count did not follow push");

endmodule

>>> hdl/dtc_rp_back.sv
// Back end: expands queued events into result words, builds the ASCII text,
// and holds the output register. Uses dtc_rp_pkg.
module dtc_rp_back
	import dtc_rp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       evt_valid,
	output logic       evt_ready,
	input  evt_t       evt,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] code_high,
	output logic [7:0] code_low,
	output logic [6:0] letter_char,
	output logic [5:0] digit_char,
	output logic [6:0] hex_char_a,
	output logic [6:0] hex_char_b,
	output logic [6:0] hex_char_c,
	output logic [7:0] codes_found,
	output logic       status,
	output logic       last_of_run
);

	logic         out_valid_q;
	logic         split_q;
	logic [7:0]   hold_found_q;
	logic         hold_status_q;
	result_kind_t kind_q;
	logic [7:0]   hi_q, lo_q, found_q;
	logic         status_q, last_q;

	logic         load;
	logic         nxt_valid;
	logic         nxt_split;
	result_kind_t nxt_kind;
	logic [7:0]   nxt_hi, nxt_lo, nxt_found;
	logic         nxt_status, nxt_last;

	assign load      = !out_valid_q || out_ready;
	assign evt_ready = load && !split_q;

	always_comb begin
		nxt_valid  = 1'b0;
		nxt_split  = 1'b0;
		nxt_kind   = KIND_END;
		nxt_hi     = 8'd0;
		nxt_lo     = 8'd0;
		nxt_found  = hold_found_q;
		nxt_status = hold_status_q;
		nxt_last   = 1'b1;
		if (split_q) begin
			nxt_valid = 1'b1;
		end else if (evt_valid) begin
			nxt_valid = 1'b1;
			if (evt.code_v) begin
				nxt_kind   = KIND_CODE;
				nxt_hi     = evt.hi;
				nxt_lo     = evt.lo;
				nxt_found  = 8'd0;
				nxt_status = 1'b0;
				nxt_last   = !evt.end_v;
				nxt_split  = evt.end_v;
			end else begin
				nxt_found  = evt.found;
				nxt_status = evt.status;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			split_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= nxt_valid;
			split_q     <= nxt_split;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= nxt_kind;
			hi_q     <= nxt_hi;
			lo_q     <= nxt_lo;
			found_q  <= nxt_found;
			status_q <= nxt_status;
			last_q   <= nxt_last;
			if (!split_q) begin
				hold_found_q  <= evt.found;
				hold_status_q <= evt.status;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign code_high   = hi_q;
	assign code_low    = lo_q;
	assign codes_found = found_q;
	assign status      = status_q;
	assign last_of_run = last_q;

	always_comb begin
		if (kind_q == KIND_CODE) begin
			letter_char = letter_of(hi_q[7:6]);
			digit_char  = {4'b1100, hi_q[5:4]};
			hex_char_a  = hex_char(hi_q[3:0]);
			hex_char_b  = hex_char(lo_q[7:4]);
			hex_char_c  = hex_char(lo_q[3:0]);
		end else begin
			letter_char = 7'd0;
			digit_char  = 6'd0;
			hex_char_a  = 7'd0;
			hex_char_b  = 7'd0;
			hex_char_c  = 7'd0;
		end
	end

	a_split_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		split_q |-> out_valid_q && kind_q == KIND_CODE && !last_q)
		else $error("end report pending without a code word in front");

endmodule

>>> sim/dtc_rp_scoreboard.sv
// Scoreboard for dtc_response_parser_core: decodes every accepted payload byte on its own
// and compares, in order, each result word the block hands out. Depends on dtc_rp_pkg.
module dtc_rp_scoreboard
	import dtc_rp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                start_of_payload,
	input  logic [LEN_IN_W-1:0] payload_length,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [7:0]          cfg_index,
	input  logic [7:0]          cfg_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic                result_kind,
	input  logic [7:0]          code_high,
	input  logic [7:0]          code_low,
	input  logic [6:0]          letter_char,
	input  logic [5:0]          digit_char,
	input  logic [6:0]          hex_char_a,
	input  logic [6:0]          hex_char_b,
	input  logic [6:0]          hex_char_c,
	input  logic [7:0]          codes_found,
	input  logic                status,
	input  logic                last_of_run,
	output int                  mismatch_count,
	output int                  words_owed
);

	typedef struct packed {
		result_kind_t kind;
		logic [7:0]   hi;
		logic [7:0]   lo;
		logic [6:0]   letter;
		logic [5:0]   digit;
		logic [6:0]   hex_a;
		logic [6:0]   hex_b;
		logic [6:0]   hex_c;
		logic [7:0]   found;
		logic         stat;
		logic         last;
	} dtc_word_t;

	dtc_word_t predicted_words[$];

	logic [7:0]  svc_code;
	logic [7:0]  code_cap;
	logic [11:0] pos;
	logic [11:0] len_held;
	logic        count_skip;
	logic        svc_bad;
	logic [7:0]  pend_hi;
	logic [7:0]  emitted;

	function automatic logic [6:0] nib_ascii(input logic [3:0] nib);
		int ch;
		ch = (nib < 4'd10) ? "0" + nib : "A" + nib - 10;
		return ch[6:0];
	endfunction

	function automatic dtc_word_t code_word(input logic [7:0] hi, input logic [7:0] lo);
		dtc_word_t w;
		int ch;
		w = '0;
		w.kind = KIND_CODE;
		w.hi = hi;
		w.lo = lo;
		case (hi[7:6])
			2'd0: ch = "P";
			2'd1: ch = "C";
			2'd2: ch = "B";
			default: ch = "U";
		endcase
		w.letter = ch[6:0];
		ch = "0" + hi[5:4];
		w.digit = ch[5:0];
		w.hex_a = nib_ascii(hi[3:0]);
		w.hex_b = nib_ascii(lo[7:4]);
		w.hex_c = nib_ascii(lo[3:0]);
		return w;
	endfunction

	task automatic decode_byte(input logic [7:0] d, input logic sop, input logic [11:0] len);
		logic [11:0] l;
		logic [11:0] off;
		logic [11:0] rel;
		dtc_word_t   code_w;
		dtc_word_t   end_w;
		logic        got_code;
		logic        got_end;
		got_code = 1'b0;
		got_end = 1'b0;
		code_w = '0;
		end_w = '0;
		if (sop) begin
			l = len;
			if (int'(l) > MAX_PAYLOAD_BYTES_DEF)
				l = 12'(MAX_PAYLOAD_BYTES_DEF);
			if (l == 12'd0)
				l = 12'd1;
			len_held = l;
			count_skip = ~l[0];
			svc_bad = (d != svc_code);
			emitted = 8'd0;
			pos = 12'd1;
			got_end = (pos == len_held);
		end else if (pos < len_held) begin
			off = count_skip ? 12'd2 : 12'd1;
			if (!svc_bad && pos >= off) begin
				rel = pos - off;
				if (!rel[0]) begin
					pend_hi = d;
				end else if ((pend_hi | d) != 8'd0 && emitted < code_cap) begin
					code_w = code_word(pend_hi, d);
					got_code = 1'b1;
					emitted = emitted + 8'd1;
				end
			end
			pos = pos + 12'd1;
			got_end = (pos == len_held);
		end
		if (got_code) begin
			code_w.last = !got_end;
			predicted_words.push_back(code_w);
		end
		if (got_end) begin
			end_w.kind = KIND_END;
			end_w.found = svc_bad ? 8'd0 : emitted;
			end_w.stat = svc_bad;
			end_w.last = 1'b1;
			predicted_words.push_back(end_w);
		end
	endtask

	task automatic report(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("%s is 0x%0h, want 0x%0h", name, got, want));
	endtask

	task automatic compare_word();
		dtc_word_t w;
		if (predicted_words.size() == 0) begin
			report($sformatf("word out with none predicted (kind %0d)", result_kind));
		end else begin
			w = predicted_words.pop_front();
			check_field("result_kind", result_kind, w.kind);
			check_field("code_high", code_high, w.hi);
			check_field("code_low", code_low, w.lo);
			check_field("letter_char", letter_char, w.letter);
			check_field("digit_char", digit_char, w.digit);
			check_field("hex_char_a", hex_char_a, w.hex_a);
			check_field("hex_char_b", hex_char_b, w.hex_b);
			check_field("hex_char_c", hex_char_c, w.hex_c);
			check_field("codes_found", codes_found, w.found);
			check_field("status", status, w.stat);
			check_field("last_of_run", last_of_run, w.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predicted_words.delete();
			svc_code = SERVICE_CODE_RST;
			code_cap = CODE_LIMIT_RST;
			pos = '0;
			len_held = '0;
			count_skip = 1'b0;
			svc_bad = 1'b0;
			pend_hi = '0;
			emitted = '0;
			mismatch_count = 0;
			words_owed = 0;
		end else begin
			if (out_valid && out_ready)
				compare_word();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SERVICE_CODE: svc_code = cfg_data;
					REG_CODE_LIMIT:   code_cap = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				decode_byte(data_byte, start_of_payload, payload_length);
			words_owed = predicted_words.size();
		end
	end

endmodule

>>> sim/tb_dtc_response_parser_core.sv
// Testbench top for dtc_response_parser_core: directed and random payload streams under
// several register settings and flow-control mixes; checking is done by dtc_rp_scoreboard.
// Depends on dtc_rp_pkg, dtc_response_parser_core and dtc_rp_scoreboard.
module tb_dtc_response_parser_core;
	import dtc_rp_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 3;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES   = 280;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [7:0]          data_byte;
	logic                start_of_payload;
	logic [LEN_IN_W-1:0] payload_length;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_index;
	logic [7:0]          cfg_data;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                result_kind;
	logic [7:0]          code_high;
	logic [7:0]          code_low;
	logic [6:0]          letter_char;
	logic [5:0]          digit_char;
	logic [6:0]          hex_char_a;
	logic [6:0]          hex_char_b;
	logic [6:0]          hex_char_c;
	logic [7:0]          codes_found;
	logic                status;
	logic                last_of_run;
	int                  mismatch_count;
	int                  words_owed;

	int         snd_idle = 0;
	int         rcv_stall = 0;
	logic       hold_req = 1'b0;
	int         hold_count = 0;
	int         quiet_cycles = 0;
	int         bytes_sent;
	logic       payload_open;
	logic [7:0] cur_svc;

	always #HALF_PERIOD clk = ~clk;

	dtc_response_parser_core i_dut (.*);

	dtc_rp_scoreboard i_board (.*);

	// receiver; a long hold-off fills the block and backs up the input
	always @(negedge clk) begin
		if (hold_req && hold_count < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= rcv_stall);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic sop, input logic [11:0] len);
		while ($urandom_range(99, 0) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		start_of_payload <= sop;
		payload_length <= len;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] svc, input logic [7:0] cap);
		cfg_valid <= 1'b1;
		cfg_index <= REG_SERVICE_CODE;
		cfg_data <= svc;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= REG_CODE_LIMIT;
		cfg_data <= cap;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_svc = svc;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (words_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// sends the first n_bytes of a payload; code pairs are random, some padding
	task automatic send_payload(input logic [11:0] len_field, input int n_bytes,
		input logic [7:0] svc, input int pad_pct);
		int         eff;
		int         off;
		int         r;
		logic [7:0] hi;
		logic [7:0] lo_next;
		eff = (len_field == 12'd0) ? 1 : int'(len_field);
		off = (eff % 2 == 0) ? 2 : 1;
		lo_next = 8'd0;
		for (int i = 0; i < n_bytes; i++) begin
			if (i == 0) begin
				send_byte(svc, 1'b1, len_field);
			end else if (i < off) begin
				send_byte(8'($urandom_range(255, 0)), 1'b0, 12'($urandom_range(4095, 0)));
			end else if ((i - off) % 2 == 0) begin
				r = $urandom_range(99, 0);
				hi = 8'($urandom_range(255, 0));
				lo_next = 8'($urandom_range(255, 0));
				if (r < pad_pct) begin
					hi = 8'd0;
					lo_next = 8'd0;
				end else if (r < pad_pct + 5) begin
					hi = 8'd0;
				end else if (r < pad_pct + 10) begin
					lo_next = 8'd0;
				end
				send_byte(hi, 1'b0, 12'($urandom_range(4095, 0)));
			end else begin
				send_byte(lo_next, 1'b0, 12'($urandom_range(4095, 0)));
			end
		end
		bytes_sent += n_bytes;
		payload_open = (n_bytes < eff);
	endtask

	task automatic random_payload();
		int         sel;
		int         len;
		int         eff;
		int         cut;
		logic [7:0] svc;
		sel = $urandom_range(99, 0);
		svc = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 0)) : cur_svc;
		if (sel < 5 && !payload_open) begin
			// stray byte between payloads, dropped by the block
			send_byte(8'($urandom_range(255, 0)), 1'b0, 12'($urandom_range(4095, 0)));
		end else if (sel < 13) begin
			// any length, usually cut short by the next start
			len = $urandom_range(4095, 0);
			eff = (len == 0) ? 1 : len;
			cut = $urandom_range(6, 1);
			send_payload(12'(len), (cut < eff) ? cut : eff, svc, 20);
		end else begin
			len = ($urandom_range(99, 0) < 85) ? $urandom_range(24, 0) : $urandom_range(120, 25);
			send_payload(12'(len), (len == 0) ? 1 : len, svc, 15);
		end
	endtask

	task automatic run_phase(input logic [7:0] svc, input logic [7:0] cap, input int snd,
		input int rcv, input logic hold);
		int target;
		settle();
		set_config(svc, cap);
		snd_idle = snd;
		rcv_stall = rcv;
		if (hold)
			hold_req <= 1'b1;
		target = bytes_sent + PHASE_BYTES;
		while (bytes_sent < target)
			random_payload();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		start_of_payload = 1'b0;
		payload_length = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SERVICE_CODE;
		cfg_data = '0;
		bytes_sent = 0;
		payload_open = 1'b0;
		cur_svc = SERVICE_CODE_RST;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed, reset register values
		send_byte(8'hA5, 1'b0, 12'hFFF);
		send_byte(8'h43, 1'b1, 12'd0);
		send_byte(8'h00, 1'b1, 12'd1);
		send_byte(8'h43, 1'b1, 12'd5);
		send_byte(8'h00, 1'b0, 12'd0);
		send_byte(8'h00, 1'b0, 12'd0);
		send_byte(8'hFF, 1'b0, 12'd0);
		send_byte(8'hFF, 1'b0, 12'd0);
		send_byte(8'h43, 1'b1, 12'd8);
		send_byte(8'h03, 1'b0, 12'd0);
		send_byte(8'h12, 1'b0, 12'd0);
		send_byte(8'h34, 1'b0, 12'd0);
		send_byte(8'h45, 1'b0, 12'd0);
		send_byte(8'h67, 1'b0, 12'd0);
		send_byte(8'h8A, 1'b0, 12'd0);
		send_byte(8'hBC, 1'b0, 12'd0);
		// longest length, abandoned with a high byte pending
		send_byte(8'h43, 1'b1, 12'd4095);
		send_byte(8'h6A, 1'b0, 12'd0);
		send_byte(8'h7B, 1'b0, 12'd0);
		send_byte(8'h2F, 1'b0, 12'd0);
		send_byte(8'h44, 1'b1, 12'd3);
		send_byte(8'h12, 1'b0, 12'd0);
		send_byte(8'h34, 1'b0, 12'd0);

		run_phase(8'h43, 8'd255, 0, 0, 1'b0);
		// more codes than the largest limit
		send_payload(12'd601, 601, 8'h43, 0);
		run_phase(8'h00, 8'd0, 45, 0, 1'b0);
		run_phase(8'hFF, 8'd3, 0, 45, 1'b0);
		run_phase(8'h47, 8'd32, 6, 6, 1'b0);
		run_phase(8'h4A, 8'd8, 0, 0, 1'b1);
		settle();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
